// ===== hdl/msac_pkg.sv =====
package msac_pkg;

  // Field widths
  localparam int SPEED_W = 24;
  localparam int BLEND_W = 17;
  localparam int WLEN_W  = 7;

  // Fixed-point constants
  localparam logic [BLEND_W-1:0] BLEND_ONE = 17'h10000;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 24'hFFFFFF;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_REFERENCE_SPEED   = 2'd0,
    REG_MEAN_BLEND        = 2'd1,
    REG_WINDOW_LENGTH     = 2'd2,
    REG_INITIAL_FRICTION  = 2'd3
  } reg_idx_t;

  // Register reset values
  localparam logic [SPEED_W-1:0] RST_REFERENCE_SPEED  = 24'd655360;
  localparam logic [BLEND_W-1:0] RST_MEAN_BLEND       = 17'd6554;
  localparam logic [WLEN_W-1:0]  RST_WINDOW_LENGTH    = 7'd60;
  localparam logic [SPEED_W-1:0] RST_INITIAL_FRICTION = 24'd32768;

  // Serial divider: one quotient bit per cycle
  localparam int QUO_W = SPEED_W;
  localparam int CNT_W = $clog2(QUO_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_AVG,
    ST_MUL,
    ST_SCALE_LOAD,
    ST_DIV_SCL,
    ST_BLEND_MUL,
    ST_BLEND_ADD
  } state_t;

endpackage

// ===== hdl/msac_if.sv =====
// Sample channel: one wind-speed measurement per item
interface msac_in_if;
  import msac_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [SPEED_W-1:0] measured_speed;

  modport source (output valid, func, measured_speed, input ready);
  modport sink   (input valid, func, measured_speed, output ready);
endinterface

// Result channel: average, friction velocity and fault flag
interface msac_out_if;
  import msac_pkg::*;
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] average_speed;
  logic [SPEED_W-1:0] friction_velocity;
  logic               divide_fault;

  modport source (output valid, average_speed, friction_velocity, divide_fault,
                  input ready);
  modport sink   (input valid, average_speed, friction_velocity, divide_fault,
                  output ready);
endinterface

// ===== hdl/moving_average_speed_controller.sv =====
// Moving-average wind speed controller.
// sample channel (valid/ready): func (0 new step, 1 repeat) and a Q8.16 speed.
// result channel (valid/ready): window average, friction velocity, fault flag;
// exactly one result item per sample item, in order.
// APB port: reference_speed 0x0, mean_blend 0x4, window_length 0x8,
// initial_friction_velocity 0xC; write only while the block is idle.
// One item is worked on at a time. The average comes from a restoring
// divider that produces one quotient bit per cycle, holding the last bit
// while the output register is full; a new step after the first runs the
// same divider again to scale the friction velocity by reference/average,
// unless the average is zero (fault) or the scaled value saturates.
// A first item, a repeat or a faulted update is done after the average
// divide; a friction update then multiplies, scales and blends. The next
// item is taken the cycle after the result is loaded, and not before.
// A stalled receiver holds the result; the next item is still accepted
// and worked on, and waits for the output register to free.
// Reset (rst, synchronous) clears the window, the started flag and the
// result valid, and restores the register defaults. The sample history
// memory is not cleared; the fill count guards every read of it.
module moving_average_speed_controller
  import msac_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  msac_in_if.sink               sample,
  msac_out_if.source            result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = SPEED_W + FILL_W;
  localparam int OFS_W  = FILL_W + 2;
  localparam int PROD_W = 2 * SPEED_W;
  localparam int BPRD_W = BLEND_W + 1 + SPEED_W + 1;

  // Configuration registers
  logic [SPEED_W-1:0] reference_speed;
  logic [BLEND_W-1:0] mean_blend;
  logic [WLEN_W-1:0]  window_length;
  logic [SPEED_W-1:0] initial_friction;

  // Window state
  logic [SPEED_W-1:0] history [WINDOW_MAX];
  logic [SPEED_W-1:0] hist_rdata;
  logic [SLOT_W-1:0]  newest_slot;
  logic [SUM_W-1:0]   window_sum;
  logic [FILL_W-1:0]  fill_count;
  logic [SPEED_W-1:0] current_friction;
  logic               started;

  // Item context
  logic               op_repeat;
  logic               op_first;
  logic               op_sub;
  logic [SPEED_W-1:0] op_speed;
  logic               fault;
  logic [SPEED_W-1:0] avg;

  // Arithmetic registers
  logic [PROD_W-1:0]        prod;
  logic signed [BPRD_W-1:0] bprod;
  logic [SPEED_W-1:0]       div_rem;
  logic [SPEED_W-1:0]       div_acc;
  logic [SPEED_W-1:0]       div_den;
  logic [CNT_W-1:0]         div_cnt;

  // Output register
  logic               out_valid;
  logic [SPEED_W-1:0] out_avg;
  logic [SPEED_W-1:0] out_fric;
  logic               out_fault;

  state_t state, state_next;

  logic accept;
  logic cfg_write;
  logic out_free;
  logic div_last;

  assign accept    = sample.valid && sample.ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign out_free  = !out_valid || result.ready;
  assign div_last  = (div_cnt == CNT_W'(QUO_W - 1));

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_speed  <= RST_REFERENCE_SPEED;
      mean_blend       <= RST_MEAN_BLEND;
      window_length    <= RST_WINDOW_LENGTH;
      initial_friction <= RST_INITIAL_FRICTION;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_REFERENCE_SPEED:  reference_speed  <= pwdata[SPEED_W-1:0];
        REG_MEAN_BLEND:       mean_blend       <= pwdata[BLEND_W-1:0];
        REG_WINDOW_LENGTH:    window_length    <= pwdata[WLEN_W-1:0];
        REG_INITIAL_FRICTION: initial_friction <= pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_REFERENCE_SPEED:  prdata = CFG_DATA_W'(reference_speed);
      REG_MEAN_BLEND:       prdata = CFG_DATA_W'(mean_blend);
      REG_WINDOW_LENGTH:    prdata = CFG_DATA_W'(window_length);
      REG_INITIAL_FRICTION: prdata = CFG_DATA_W'(initial_friction);
      default:              prdata = '0;
    endcase
  end

  // Effective window length and blend weight
  logic [FILL_W-1:0]  eff_len;
  logic [BLEND_W-1:0] blend_w;

  always_comb begin
    if (window_length == '0) begin
      eff_len = FILL_W'(1);
    end else if (16'(window_length) > 16'(WINDOW_MAX)) begin
      eff_len = FILL_W'(WINDOW_MAX);
    end else begin
      eff_len = FILL_W'(window_length);
    end
    blend_w = mean_blend[BLEND_W-1] ? BLEND_ONE : mean_blend;
  end

  // Slot arithmetic: next slot after newest, and oldest slot in the window
  logic [SLOT_W-1:0]       slot_after;
  logic signed [OFS_W-1:0] oldest_ofs;
  logic [SLOT_W-1:0]       oldest_slot;
  logic                    drop_oldest;

  always_comb begin
    if ((SLOT_W + 1)'(newest_slot) + (SLOT_W + 1)'(1) >= (SLOT_W + 1)'(WINDOW_MAX)) begin
      slot_after = '0;
    end else begin
      slot_after = newest_slot + SLOT_W'(1);
    end
    oldest_ofs = $signed(OFS_W'(newest_slot)) + OFS_W'(1) - $signed(OFS_W'(fill_count));
    if (oldest_ofs < 0) begin
      oldest_ofs = oldest_ofs + OFS_W'(WINDOW_MAX);
    end
    oldest_slot = oldest_ofs[SLOT_W-1:0];
    drop_oldest = (fill_count >= eff_len) && (fill_count != '0);
  end

  // Sum and fill after this item's push or replace
  logic [SUM_W-1:0]  sum_new;
  logic [FILL_W-1:0] fill_new;

  always_comb begin
    sum_new  = window_sum + SUM_W'(op_speed) - (op_sub ? SUM_W'(hist_rdata) : '0);
    fill_new = fill_count;
    if (!op_repeat && !(drop_oldest && !op_first)) begin
      fill_new = fill_count + FILL_W'(1);
    end
    if (op_first && drop_oldest) begin
      fill_new = fill_count;
    end
  end

  // Divider step: one quotient bit per cycle while div_step is set
  logic [SPEED_W:0]   div_trial;
  logic               div_ge;
  logic [SPEED_W:0]   div_diff;
  logic [SPEED_W-1:0] rem_next;
  logic [SPEED_W-1:0] acc_next;

  always_comb begin
    div_trial = {div_rem, div_acc[SPEED_W-1]};
    div_diff  = div_trial - {1'b0, div_den};
    div_ge    = (div_trial >= {1'b0, div_den});
    rem_next  = div_ge ? div_diff[SPEED_W-1:0] : div_trial[SPEED_W-1:0];
    acc_next  = {div_acc[SPEED_W-2:0], div_ge};
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (accept) state_next = ST_SUM;
      ST_SUM:        state_next = ST_DIV_AVG;
      ST_DIV_AVG: begin
        if (div_last) begin
          if (op_first || op_repeat || acc_next == '0) begin
            state_next = out_free ? ST_IDLE : ST_DIV_AVG;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL:        state_next = ST_SCALE_LOAD;
      ST_SCALE_LOAD: begin
        if (prod[PROD_W-1:SPEED_W] >= avg) state_next = ST_BLEND_MUL;
        else state_next = ST_DIV_SCL;
      end
      ST_DIV_SCL:    if (div_last) state_next = ST_BLEND_MUL;
      ST_BLEND_MUL:  state_next = ST_BLEND_ADD;
      ST_BLEND_ADD:  if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  logic result_load;
  logic div_step;

  always_comb begin
    sample.ready = 1'b0;
    result_load  = 1'b0;
    div_step     = 1'b0;
    unique case (state)
      ST_IDLE:      sample.ready = 1'b1;
      ST_DIV_AVG: begin
        div_step    = !div_last || state_next != ST_DIV_AVG;
        result_load = div_last && state_next == ST_IDLE;
      end
      ST_DIV_SCL:   div_step = 1'b1;
      ST_BLEND_ADD: result_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // History memory: read at accept, written in the sum cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      hist_rdata <= history[(started && sample.func) ? newest_slot : oldest_slot];
    end
    if (state == ST_SUM) begin
      history[op_repeat ? newest_slot : slot_after] <= op_speed;
    end
  end

  // Item context
  always_ff @(posedge clk) begin
    if (accept) begin
      op_first  <= !started;
      op_repeat <= started && sample.func;
      op_sub    <= (started && sample.func) || drop_oldest;
      op_speed  <= sample.measured_speed;
    end
  end

  // Window and friction state
  always_ff @(posedge clk) begin
    if (rst) begin
      newest_slot      <= '0;
      window_sum       <= '0;
      fill_count       <= '0;
      current_friction <= '0;
      started          <= 1'b0;
    end else begin
      if (state == ST_SUM) begin
        window_sum <= sum_new;
        fill_count <= fill_new;
        if (!op_repeat) newest_slot <= slot_after;
        if (op_first) begin
          current_friction <= initial_friction;
          started          <= 1'b1;
        end
      end
      if (state == ST_BLEND_ADD && out_free) begin
        current_friction <= current_friction + bprod[16 +: SPEED_W];
      end
    end
  end

  // Divider, multipliers and item results
  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      div_rem <= SPEED_W'(sum_new[SUM_W-1:SPEED_W]);
      div_acc <= sum_new[SPEED_W-1:0];
      div_den <= SPEED_W'(fill_new);
      div_cnt <= '0;
      fault   <= 1'b0;
    end
    if (div_step) begin
      div_rem <= rem_next;
      div_acc <= acc_next;
      div_cnt <= div_last ? '0 : div_cnt + CNT_W'(1);
    end
    if (state == ST_DIV_AVG && div_last) begin
      avg   <= acc_next;
      fault <= !op_first && !op_repeat && acc_next == '0;
    end
    if (state == ST_MUL) begin
      prod <= current_friction * reference_speed;
    end
    if (state == ST_SCALE_LOAD) begin
      if (prod[PROD_W-1:SPEED_W] >= avg) begin
        div_acc <= SPEED_MAX;
      end else begin
        div_rem <= prod[PROD_W-1:SPEED_W];
        div_acc <= prod[SPEED_W-1:0];
        div_den <= avg;
        div_cnt <= '0;
      end
    end
    // b * (scaled - u), signed
    if (state == ST_BLEND_MUL) begin
      bprod <= BPRD_W'($signed({1'b0, blend_w}))
               * (BPRD_W'($signed({1'b0, div_acc}))
                  - BPRD_W'($signed({1'b0, current_friction})));
    end
  end

  // Output register
  logic [SPEED_W-1:0] fric_result;

  assign fric_result = (state == ST_BLEND_ADD)
                       ? current_friction + bprod[16 +: SPEED_W]
                       : (op_first ? current_friction : current_friction);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_fric <= fric_result;
      if (state == ST_DIV_AVG) begin
        out_avg   <= acc_next;
        out_fault <= !op_first && !op_repeat && acc_next == '0;
      end else begin
        out_avg   <= avg;
        out_fault <= fault;
      end
    end
  end

  assign result.valid             = out_valid;
  assign result.average_speed     = out_avg;
  assign result.friction_velocity = out_fric;
  assign result.divide_fault      = out_fault;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) <= WINDOW_MAX)
    else $error("fill count above window size");

  a_fault_zero_avg: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.divide_fault |-> result.average_speed == '0)
    else $error("fault flagged with nonzero average");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SUM && !sample.ready)
    else $error("item accepted but block not busy");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid && $stable(out_avg) && $stable(out_fric))
    else $error("stalled result changed");
`endif

endmodule

// ===== tb/sv/tb_moving_average_speed_controller.sv =====
module tb_moving_average_speed_controller;
  import msac_pkg::*;

  localparam int WINDOW_DEPTH = 64;
  localparam int STALL_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 80;
  localparam int REPORT_MAX   = 10;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct packed {
    logic [SPEED_W-1:0] average_speed;
    logic [SPEED_W-1:0] friction_velocity;
    logic               divide_fault;
  } speed_result_t;

  // Directed items, {func, measured_speed}; window of one sample
  localparam logic [SPEED_W:0] SINGLE_SLOT_STEPS [8] = '{
    {1'b1, 24'h123456},   // first item flagged as repeat still opens the window
    {1'b0, 24'h000000},   // zero average on an update
    {1'b1, 24'hFFFFFF},   // repeat at full scale
    {1'b0, 24'hFFFFFF},
    {1'b0, 24'h000001},   // tiny average, scaled value saturates
    {1'b1, 24'h000000},   // repeat down to zero
    {1'b0, 24'h000000},   // zero average again
    {1'b0, 24'h0A0000}
  };

  // Directed items with full reference speed and blend above one
  localparam logic [SPEED_W:0] FULL_BLEND_STEPS [4] = '{
    {1'b0, 24'h000001},
    {1'b1, 24'h800000},
    {1'b0, 24'h7FFFFF},
    {1'b0, 24'h000000}
  };

  // Window, running sum and friction velocity tracking plus expected results
  class friction_predictor;
    bit [SPEED_W-1:0] ref_speed;
    bit [BLEND_W-1:0] blend;
    bit [WLEN_W-1:0]  win_len;
    bit [SPEED_W-1:0] init_friction;
    bit [SPEED_W-1:0] samples [WINDOW_DEPTH];
    int unsigned      newest;
    int unsigned      fill;
    bit [63:0]        sum;
    bit [SPEED_W-1:0] friction;
    bit               started;
    speed_result_t    expected_results [$];
    int unsigned      mismatches;

    function new();
      ref_speed     = RST_REFERENCE_SPEED;
      blend         = RST_MEAN_BLEND;
      win_len       = RST_WINDOW_LENGTH;
      init_friction = RST_INITIAL_FRICTION;
      newest        = 0;
      fill          = 0;
      sum           = '0;
      friction      = '0;
      started       = 1'b0;
      mismatches    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, bit [CFG_DATA_W-1:0] value);
      case (idx)
        REG_REFERENCE_SPEED:  ref_speed     = value[SPEED_W-1:0];
        REG_MEAN_BLEND:       blend         = value[BLEND_W-1:0];
        REG_WINDOW_LENGTH:    win_len       = value[WLEN_W-1:0];
        REG_INITIAL_FRICTION: init_friction = value[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    // New step: drop the oldest once full, then append
    function void push_speed(bit [SPEED_W-1:0] m);
      int unsigned span;
      int unsigned oldest;
      span = (win_len == 0) ? 1 : (win_len > WINDOW_DEPTH) ? WINDOW_DEPTH : win_len;
      if (fill >= span && fill > 0) begin
        oldest = (newest + WINDOW_DEPTH + 1 - fill) % WINDOW_DEPTH;
        sum -= samples[oldest];
      end else begin
        fill++;
      end
      newest = (newest + 1) % WINDOW_DEPTH;
      samples[newest] = m;
      sum += m;
    endfunction

    // Note one accepted item and queue the result it causes
    function void take_sample(bit repeat_step, bit [SPEED_W-1:0] m);
      bit            update;
      bit [63:0]     mean_val;
      bit [63:0]     u;
      bit [63:0]     b;
      bit [63:0]     scaled;
      speed_result_t want;
      update = 1'b0;
      want   = '0;
      if (!started) begin
        friction = init_friction;
        started  = 1'b1;
        push_speed(m);
      end else if (repeat_step) begin
        sum -= samples[newest];
        samples[newest] = m;
        sum += m;
      end else begin
        push_speed(m);
        update = 1'b1;
      end

      mean_val = (fill > 0) ? sum / fill : 64'd0;
      want.average_speed = mean_val[SPEED_W-1:0];

      // Friction update: scale by reference/average, blend with old value
      if (update) begin
        if (want.average_speed == 0) begin
          want.divide_fault = 1'b1;
        end else begin
          u      = friction;
          b      = (blend > BLEND_ONE) ? 64'(BLEND_ONE) : 64'(blend);
          scaled = (u * 64'(ref_speed)) / 64'(want.average_speed);
          if (scaled > 64'(SPEED_MAX)) scaled = 64'(SPEED_MAX);
          u = (b * scaled + (64'(BLEND_ONE) - b) * u) >> 16;
          friction = u[SPEED_W-1:0];
        end
      end
      want.friction_velocity = friction;
      expected_results.push_back(want);
    endfunction

    function void compare_result(speed_result_t got);
      speed_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result item: avg %h u %h fault %b",
                   got.average_speed, got.friction_velocity, got.divide_fault);
        return;
      end
      want = expected_results.pop_front();
      if (got.average_speed !== want.average_speed ||
          got.friction_velocity !== want.friction_velocity ||
          got.divide_fault !== want.divide_fault) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: avg %h/%h u %h/%h fault %b/%b (expected/actual)",
                   want.average_speed, got.average_speed,
                   want.friction_velocity, got.friction_velocity,
                   want.divide_fault, got.divide_fault);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned      src_idle_pct;
  int unsigned      sink_idle_pct;
  int unsigned      idle_cycles;
  int unsigned      rand_sent;
  logic [SPEED_W-1:0] cur_ref;

  friction_predictor tracker;

  msac_in_if  sample_ch ();
  msac_out_if result_ch ();

  moving_average_speed_controller #(
    .WINDOW_MAX (WINDOW_DEPTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random back-pressure on the result channel
  always @(negedge clk) begin
    result_ch.ready = ($urandom_range(99) >= sink_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      tracker.compare_result({result_ch.average_speed, result_ch.friction_velocity,
                              result_ch.divide_fault});
  end

  // Watchdog: no item and no register write for too long
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
        || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // APB write: setup then access phase
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_config(input logic [SPEED_W-1:0] ref_val, input logic [BLEND_W-1:0] blend,
                             input logic [WLEN_W-1:0] win_len,
                             input logic [SPEED_W-1:0] friction0);
    write_reg(REG_REFERENCE_SPEED, CFG_DATA_W'(ref_val));
    write_reg(REG_MEAN_BLEND, CFG_DATA_W'(blend));
    write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(win_len));
    write_reg(REG_INITIAL_FRICTION, CFG_DATA_W'(friction0));
    cur_ref = ref_val;
  endtask

  // Offer one item, with random gaps ahead of it
  task automatic send_sample(input logic func_bit, input logic [SPEED_W-1:0] speed);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid          = 1'b0;
      sample_ch.func           = 1'($urandom_range(1));
      sample_ch.measured_speed = SPEED_W'($urandom);
      @(negedge clk);
    end
    sample_ch.valid          = 1'b1;
    sample_ch.func           = func_bit;
    sample_ch.measured_speed = speed;
    do @(posedge clk); while (!sample_ch.ready);
    tracker.take_sample(func_bit, speed);
    @(negedge clk);
  endtask

  // Hold off the sender until every pending result is back
  task automatic drain();
    sample_ch.valid = 1'b0;
    while (tracker.expected_results.size() != 0) @(negedge clk);
  endtask

  // Random items: speeds mostly near the reference, some extremes and zero runs
  task automatic run_random(input int unsigned count);
    logic               func_bit;
    logic [SPEED_W-1:0] speed;
    int unsigned        zero_run;
    int unsigned        near;
    zero_run = 0;
    for (int unsigned k = 0; k < count; k++) begin
      if (rand_sent < RANDOM_ITEMS / 3) begin
        src_idle_pct  = 15;
        sink_idle_pct = 68;
      end else if (rand_sent < 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct  = 68;
        sink_idle_pct = 15;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (k == count / 2) drain();

      func_bit = ($urandom_range(3) == 0);
      if (zero_run > 0) begin
        speed = '0;
        zero_run--;
      end else begin
        if ($urandom_range(149) == 0) zero_run = $urandom_range(70, 4);
        case ($urandom_range(9))
          0: speed = SPEED_W'($urandom);
          1: speed = SPEED_MAX;
          2: speed = SPEED_W'($urandom_range(255));
          default: begin
            near  = cur_ref - cur_ref / 4 + $urandom_range(cur_ref / 2);
            speed = (near > SPEED_MAX) ? SPEED_MAX : near[SPEED_W-1:0];
          end
        endcase
      end
      send_sample(func_bit, speed);
      rand_sent++;
    end
  endtask

  initial begin
    tracker                  = new();
    rst                      = 1'b1;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    sample_ch.valid          = 1'b0;
    sample_ch.func           = 1'b0;
    sample_ch.measured_speed = '0;
    src_idle_pct             = 15;
    sink_idle_pct            = 68;
    rand_sent                = 0;
    cur_ref                  = RST_REFERENCE_SPEED;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: single-sample window, full initial friction
    load_config(24'd655360, 17'd6554, 7'd1, SPEED_MAX);
    foreach (SINGLE_SLOT_STEPS[i])
      send_sample(SINGLE_SLOT_STEPS[i][SPEED_W], SINGLE_SLOT_STEPS[i][SPEED_W-1:0]);
    drain();

    // Directed: zero window length, blend above one, full reference
    load_config(SPEED_MAX, 17'h1FFFF, 7'd0, '0);
    foreach (FULL_BLEND_STEPS[i])
      send_sample(FULL_BLEND_STEPS[i][SPEED_W], FULL_BLEND_STEPS[i][SPEED_W-1:0]);
    drain();

    // Random phases; window shrinks below its fill, then grows to the limit
    load_config(24'd655360, 17'd6554, 7'd8, '0);
    run_random(200);
    drain();
    load_config(SPEED_W'($urandom_range(24'h200000, 24'h040000)), 17'd0, 7'd3,
                SPEED_W'($urandom));
    run_random(150);
    drain();
    load_config(SPEED_W'($urandom_range(24'h200000, 24'h040000)), BLEND_ONE, 7'd100,
                SPEED_W'($urandom));
    run_random(200);
    drain();
    load_config(SPEED_W'($urandom_range(24'h200000, 24'h040000)),
                BLEND_W'($urandom_range(65536)),
                WLEN_W'($urandom_range(64, 1)), SPEED_W'($urandom));
    run_random(250);
    drain();
    load_config(SPEED_W'($urandom_range(24'h200000, 24'h040000)),
                BLEND_W'($urandom_range(65536)), 7'd64, SPEED_W'($urandom));
    run_random(200);
    drain();
    load_config(SPEED_MAX, BLEND_W'($urandom_range(65536, 1)), 7'd64, SPEED_MAX);
    run_random(150);
    drain();
    // Zero reference pulls the friction velocity toward zero
    load_config('0, BLEND_W'($urandom_range(65536, 1)), WLEN_W'($urandom_range(64, 1)),
                SPEED_W'($urandom));
    run_random(100);
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
